// File: rtl/skng_pkg.sv
// Package: shared types and constants for the soft-knee noise gate expander.
package skng_pkg;

  localparam int DB_W    = 15;
  localparam int RATIO_W = 15;
  localparam int GAIN_W  = 16;
  localparam int WIDE_W  = 48;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // latch input beat
    logic mul_en;    // run one multiplier step
    logic [2:0] sel; // which product
    logic crv;       // register both curve values
    logic upd;       // final update of state and result
  } skng_cmd_t;

  localparam logic [2:0] SEL_U_LIN  = 3'd0;
  localparam logic [2:0] SEL_U_KA   = 3'd1;
  localparam logic [2:0] SEL_U_KB   = 3'd2;
  localparam logic [2:0] SEL_L_LIN  = 3'd3;
  localparam logic [2:0] SEL_L_KA   = 3'd4;
  localparam logic [2:0] SEL_L_KB   = 3'd5;
  localparam logic [2:0] SEL_U_KC   = 3'd6;
  localparam logic [2:0] SEL_L_KC   = 3'd7;

endpackage

// File: rtl/skng_datapath.sv
// Datapath: curve evaluation with one shared multiplier, clamp and gain.
module skng_datapath #(
  parameter int DB_FRAC_BITS = 6
) (
  input  logic                                clk,
  input  skng_pkg::skng_cmd_t                 cmd,
  input  logic                                rst,
  input  logic signed [skng_pkg::DB_W-1:0]    level_in,
  input  logic signed [skng_pkg::DB_W-1:0]    threshold_level,
  input  logic        [skng_pkg::RATIO_W-1:0] upper_ratio,
  input  logic        [skng_pkg::RATIO_W-1:0] lower_ratio,
  input  logic signed [skng_pkg::DB_W-1:0]    reduction_floor,
  output logic signed [skng_pkg::GAIN_W-1:0]  gain
);
  localparam int W = skng_pkg::WIDE_W;
  localparam int KNEE = 4 <<< DB_FRAC_BITS;
  localparam int KSH  = 12 + DB_FRAC_BITS;
  localparam int K2SH = 3 + DB_FRAC_BITS; // twice the knee is a power of two
  localparam int MA_W = 20 + DB_FRAC_BITS;
  localparam int MB_W = 16;
  localparam logic signed [W-1:0] KNEE_W = W'(KNEE);
  localparam logic signed [W-1:0] K2_W   = W'(2 * KNEE);
  localparam logic signed [W-1:0] POS_SAT = W'(32767);
  localparam logic signed [W-1:0] NEG_SAT = W'(-32768);
  localparam int RST_RAW = -(150 <<< DB_FRAC_BITS);
  localparam logic signed [15:0] OUT_RST =
    (RST_RAW < -32768) ? 16'sh8000 : 16'(RST_RAW);

  logic signed [W-1:0] x, t;
  logic signed [W-1:0] u_lin, u_ka, u_kb, l_lin, l_ka, l_kb;
  logic signed [15:0] output_level, previous_level;

  // operand selection for the shared multiplier; knee terms take two passes
  logic signed [W-1:0] tl, eu, el;
  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic signed [MA_W+MB_W-1:0] prod;
  always_comb begin
    tl = t + KNEE_W;
    eu = x - t + KNEE_W;
    el = x - tl + KNEE_W;
    case (cmd.sel)
      skng_pkg::SEL_U_LIN: begin
        ma = MA_W'(x - t);               mb = MB_W'(upper_ratio);
      end
      skng_pkg::SEL_U_KA: begin
        ma = MA_W'(eu - K2_W);           mb = MB_W'(upper_ratio);
      end
      skng_pkg::SEL_U_KB: begin
        ma = MA_W'(K2_W - eu);           mb = MB_W'(upper_ratio);
      end
      skng_pkg::SEL_U_KC: begin
        ma = MA_W'((eu <<< 8) + u_kb);   mb = MB_W'(eu);
      end
      skng_pkg::SEL_L_LIN: begin
        ma = MA_W'(x - tl);              mb = MB_W'(lower_ratio);
      end
      skng_pkg::SEL_L_KA: begin
        ma = MA_W'(el - K2_W);           mb = MB_W'(lower_ratio);
      end
      skng_pkg::SEL_L_KB: begin
        ma = MA_W'(K2_W - el);           mb = MB_W'(lower_ratio);
      end
      skng_pkg::SEL_L_KC: begin
        ma = MA_W'((el <<< 8) + l_kb);   mb = MB_W'(el);
      end
      default: begin ma = '0; mb = '0; end
    endcase
    prod = ma * mb;
  end

  function automatic logic signed [W-1:0] rshift(input logic signed [W-1:0] n,
                                                 input int s);
    logic signed [W-1:0] v;
    v = n + (W'(1) <<< (s - 1));
    return v >>> s;
  endfunction

  logic signed [W-1:0] upper_next, lower_next, upper, lower;
  always_comb begin
    if (x <= t - KNEE_W) upper_next = t + rshift(u_lin, 8);
    else if (x >= t + KNEE_W) upper_next = x;
    else upper_next = t + rshift((u_ka <<< K2SH) + u_kb, KSH);
    if (x <= tl - KNEE_W) lower_next = tl + rshift(l_lin, 8);
    else if (x >= tl + KNEE_W) lower_next = x;
    else lower_next = tl + rshift((l_ka <<< K2SH) + l_kb, KSH);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= W'(level_in);
      t <= W'(threshold_level);
    end
    if (cmd.mul_en) begin
      case (cmd.sel)
        skng_pkg::SEL_U_LIN: u_lin <= W'(prod);
        skng_pkg::SEL_U_KA:  u_ka  <= W'(prod);
        skng_pkg::SEL_U_KB,
        skng_pkg::SEL_U_KC:  u_kb  <= W'(prod);
        skng_pkg::SEL_L_LIN: l_lin <= W'(prod);
        skng_pkg::SEL_L_KA:  l_ka  <= W'(prod);
        skng_pkg::SEL_L_KB,
        skng_pkg::SEL_L_KC:  l_kb  <= W'(prod);
        default: ;
      endcase
    end
    if (cmd.crv) begin
      upper <= upper_next;
      lower <= lower_next;
    end
  end

  logic signed [W-1:0] desired, outw, g;
  always_comb begin
    desired = W'(output_level) + x - W'(previous_level);
    if (desired < lower) desired = lower;
    else if (desired > upper) desired = upper;
    if (desired > POS_SAT) outw = POS_SAT;
    else if (desired < NEG_SAT) outw = NEG_SAT;
    else outw = desired;
    g = outw - x;
    if (g < W'(reduction_floor)) g = W'(reduction_floor);
    if (g > POS_SAT) g = POS_SAT;
    else if (g < NEG_SAT) g = NEG_SAT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_level   <= OUT_RST;
      previous_level <= '0;
    end else if (cmd.upd) begin
      output_level   <= outw[15:0];
      previous_level <= x[15:0];
      gain           <= g[15:0];
    end
  end
endmodule

// File: rtl/skng_ctrl.sv
// Controller: sequences load, multiplier steps, update and output beat.
module skng_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                ready,
  output logic                gain_valid,
  input  logic                gain_ready,
  output skng_pkg::skng_cmd_t cmd
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_MUL = 5'b00010, S_CRV = 5'b00100, S_UPD = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [2:0] step;

  assign ready = (state == S_IDLE);
  assign gain_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && valid;
    cmd.mul_en = (state == S_MUL);
    cmd.sel = step;
    cmd.crv = (state == S_CRV);
    cmd.upd = (state == S_UPD);
    state_next = state;
    case (state)
      S_IDLE: if (valid) state_next = S_MUL;
      S_MUL:  if (step == skng_pkg::SEL_L_KC) state_next = S_CRV;
      S_CRV:  state_next = S_UPD;
      S_UPD:  state_next = S_OUT;
      S_OUT:  if (gain_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
    end else begin
      state <= state_next;
      if (state == S_MUL) step <= step + 3'd1;
      else step <= '0;
    end
  end

`ifndef ASSERT_OFF
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_upd_then_out: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD |=> state == S_OUT) else $error("update not followed by out");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    gain_valid |-> !ready) else $error("accept while result pending");
`endif
endmodule

// File: rtl/soft_knee_noise_gate_expander.sv
// Top level: soft-knee noise gate gain computer with APB register port.
// One level beat in dB (Q9.6) gives one gain beat. From accept to gain_valid
// the accept edge loads the level, the shared multiplier then forms the
// linear and two-pass knee products of both curves, both curves are
// registered, and one update follows. The next beat is taken the cycle after
// the gain beat is consumed, so no new beat is taken while one is in flight.
// Registers: 0x0 threshold_level, 0x4 upper_ratio, 0x8 lower_ratio,
// 0xC reduction_floor; write only while idle.
module soft_knee_noise_gate_expander #(
  parameter int DB_FRAC_BITS = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               ready,
  input  logic signed [14:0] level_in,
  output logic               gain_valid,
  input  logic               gain_ready,
  output logic signed [15:0] gain_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  logic signed [14:0] threshold_level, reduction_floor;
  logic [14:0] upper_ratio, lower_ratio;
  skng_pkg::skng_cmd_t cmd;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_level <= -15'sd3840;
      upper_ratio     <= 15'd512;
      lower_ratio     <= 15'd1024;
      reduction_floor <= -15'sd6400;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        4'h0: threshold_level <= pwdata[14:0];
        4'h4: upper_ratio     <= pwdata[14:0];
        4'h8: lower_ratio     <= pwdata[14:0];
        4'hC: reduction_floor <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      4'h0: prdata = {17'd0, threshold_level};
      4'h4: prdata = {17'd0, upper_ratio};
      4'h8: prdata = {17'd0, lower_ratio};
      4'hC: prdata = {17'd0, reduction_floor};
      default: prdata = '0;
    endcase
  end

  skng_ctrl u_ctrl (
    .clk, .rst, .valid, .ready, .gain_valid, .gain_ready, .cmd
  );

  skng_datapath #(.DB_FRAC_BITS(DB_FRAC_BITS)) u_dp (
    .clk, .cmd, .rst, .level_in, .threshold_level, .upper_ratio,
    .lower_ratio, .reduction_floor, .gain(gain_out)
  );
endmodule
